@@ rtl/qte_pkg.sv @@
// Package for the quaternion to Euler angle converter.
// Holds widths, fixed-point constants, pipeline payload types and the
// arctangent table. Depends on nothing.
`timescale 1ns / 1ps

package qte_pkg;

    localparam int IN_W          = 16;   // Q1.14 quaternion component
    localparam int PROD_W        = 32;   // Q.28 product
    localparam int SUM_W         = 34;   // doubled sum of two products
    localparam int CW            = 38;   // CORDIC x/y width, covers gain
    localparam int ZW            = 35;   // angle accumulator, Q.30 radians
    localparam int ROOT_W        = 29;   // sqrt result bits, up to 2^28
    localparam int SQ_W          = 60;   // sqrt remainder width
    localparam int MAG_W         = 28;   // |sp| bits used when not clamped
    localparam int ROLL_W        = 16;
    localparam int PITCH_W       = 15;
    localparam int OUT_SHIFT     = 18;   // Q.30 doubled to Q3.12
    localparam int ARC_ITER_DEF  = 14;
    localparam int ARC_TABLE_LEN = 24;

    localparam logic signed [SUM_W-1:0] ONE_Q28     = 34'sd268435456;
    localparam logic signed [ZW-1:0]    PI_Q30      = 35'sd3373259426;
    localparam logic signed [ZW-1:0]    HALF_PI_Q30 = 35'sd1686629713;
    localparam logic signed [18:0]      FULL_LIMIT  = 19'sd25736;
    localparam logic signed [18:0]      HALF_LIMIT  = 19'sd12868;

    typedef struct packed {
        logic signed [PROD_W-1:0] wx;
        logic signed [PROD_W-1:0] yz;
        logic signed [PROD_W-1:0] xx;
        logic signed [PROD_W-1:0] yy;
        logic signed [PROD_W-1:0] wz;
        logic signed [PROD_W-1:0] xy;
        logic signed [PROD_W-1:0] zz;
        logic signed [PROD_W-1:0] wy;
        logic signed [PROD_W-1:0] zx;
    } qte_prod_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] sr;
        logic signed [SUM_W-1:0] cr;
        logic signed [SUM_W-1:0] sy;
        logic signed [SUM_W-1:0] cy;
        logic signed [SUM_W-1:0] sp;
    } qte_sum_t;

    // one slot of the square root chain, with the other operands riding along
    typedef struct packed {
        logic [SQ_W-1:0]   rem;
        logic [ROOT_W-1:0] root;
        qte_sum_t          sums;
        logic              clamp;
    } qte_sq_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 zero;
    } qte_vec_t;

    typedef struct packed {
        qte_vec_t roll;
        qte_vec_t pitch;
        qte_vec_t yaw;
        logic     clamp;
        logic     neg;
    } qte_rot_t;

    // atan(2^-i) in Q.30, truncated
    function automatic logic signed [ZW-1:0] arc_entry(input int i);
        logic signed [ZW-1:0] a;
        case (i)
            0:       a = 35'sd843314856;
            1:       a = 35'sd497837829;
            2:       a = 35'sd263043836;
            3:       a = 35'sd133525158;
            4:       a = 35'sd67021686;
            5:       a = 35'sd33543515;
            6:       a = 35'sd16775850;
            7:       a = 35'sd8388437;
            8:       a = 35'sd4194282;
            9:       a = 35'sd2097149;
            10:      a = 35'sd1048575;
            11:      a = 35'sd524287;
            12:      a = 35'sd262143;
            13:      a = 35'sd131071;
            14:      a = 35'sd65535;
            15:      a = 35'sd32767;
            16:      a = 35'sd16383;
            17:      a = 35'sd8191;
            18:      a = 35'sd4095;
            19:      a = 35'sd2047;
            20:      a = 35'sd1023;
            21:      a = 35'sd511;
            22:      a = 35'sd255;
            23:      a = 35'sd127;
            default: a = '0;
        endcase
        return a;
    endfunction

    // one vectoring micro-rotation
    function automatic qte_vec_t cordic_step(input qte_vec_t v, input int i);
        qte_vec_t             r;
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        r  = v;
        dx = v.y >>> i;
        dy = v.x >>> i;
        if (v.y > 0)
        begin
            r.x = v.x + dx;
            r.y = v.y - dy;
            r.z = v.z + arc_entry(i);
        end
        else
        begin
            r.x = v.x - dx;
            r.y = v.y + dy;
            r.z = v.z - arc_entry(i);
        end
        return r;
    endfunction

endpackage

@@ rtl/qte_if.sv @@
// Stream interfaces of the quaternion to Euler angle converter.
// Depends on qte_pkg for field widths.
`timescale 1ns / 1ps

interface qte_quat_if;
    logic                             valid;
    logic                             ready;
    logic signed [qte_pkg::IN_W-1:0]  quat_w;
    logic signed [qte_pkg::IN_W-1:0]  quat_x;
    logic signed [qte_pkg::IN_W-1:0]  quat_y;
    logic signed [qte_pkg::IN_W-1:0]  quat_z;

    modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
    modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface qte_euler_if;
    logic                                valid;
    logic                                ready;
    logic signed [qte_pkg::ROLL_W-1:0]   roll_doubled;
    logic signed [qte_pkg::PITCH_W-1:0]  pitch_doubled;
    logic signed [qte_pkg::ROLL_W-1:0]   yaw_doubled;
    logic                                pitch_clamped;

    modport source (output valid, roll_doubled, pitch_doubled, yaw_doubled,
                    pitch_clamped, input ready);
    modport sink   (input valid, roll_doubled, pitch_doubled, yaw_doubled,
                    pitch_clamped, output ready);
endinterface

@@ rtl/quaternion_to_euler_angles.sv @@
// Quaternion (Q1.14) to doubled roll/yaw (Q3.12 radians) and pitch (Q2.12).
// Data pass through the 29-cell square root row and the CORDIC row.
// Throughput: one transfer per cycle; the whole pipe holds only while the
// output register is full and not taken. Reset clears all valid flags;
// the data registers are not reset.
// Depends on qte_pkg, qte_if, qte_sqrt_cell, qte_cordic_cell.
`timescale 1ns / 1ps

module quaternion_to_euler_angles #(
    parameter int ARC_ITERATIONS = qte_pkg::ARC_ITER_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    qte_quat_if.sink    quat,
    qte_euler_if.source euler
);
    import qte_pkg::*;

    logic en;

    logic       prod_valid_reg;
    qte_prod_t  prod_reg;
    qte_prod_t  prod_next;

    logic       sum_valid_reg;
    qte_sum_t   sum_reg;
    qte_sum_t   sum_next;

    logic                  sq_valid [0:ROOT_W];
    qte_sq_t               sq_data  [0:ROOT_W];
    logic                  sq0_valid_reg;
    qte_sq_t               sq0_reg;
    qte_sq_t               sq0_next;
    logic [SUM_W-1:0]      mag;
    logic [2*MAG_W-1:0]    mag_sq;

    logic       rot_valid [0:ARC_ITERATIONS];
    qte_rot_t   rot_data  [0:ARC_ITERATIONS];
    logic       prep_valid_reg;
    qte_rot_t   prep_reg;
    qte_rot_t   prep_next;
    qte_rot_t   fin;

    logic                       out_valid_reg;
    logic signed [ROLL_W-1:0]   roll_reg;
    logic signed [ROLL_W-1:0]   roll_next;
    logic signed [PITCH_W-1:0]  pitch_reg;
    logic signed [PITCH_W-1:0]  pitch_next;
    logic signed [ROLL_W-1:0]   yaw_reg;
    logic signed [ROLL_W-1:0]   yaw_next;
    logic                       clamp_reg;
    logic signed [ZW-1:0]       pitch_ang;

    function automatic qte_vec_t prep_vec(input logic signed [SUM_W-1:0] y,
                                          input logic signed [SUM_W-1:0] x);
        qte_vec_t v;
        v.x    = CW'(x);
        v.y    = CW'(y);
        v.z    = '0;
        v.zero = (x == '0) && (y == '0);
        if (x < 0)
        begin
            v.x = -CW'(x);
            v.y = -CW'(y);
            v.z = (y >= 0) ? PI_Q30 : -PI_Q30;
        end
        return v;
    endfunction

    // round half up after doubling, then saturate
    function automatic logic signed [ROLL_W-1:0] to_out(
        input logic signed [ZW-1:0] ang,
        input logic signed [18:0]   lim
    );
        logic signed [ZW+1:0] t;
        logic signed [18:0]   r;
        t = {ang[ZW-1], ang, 1'b0} + (ZW+2)'(1 << (OUT_SHIFT - 1));
        r = $signed(t[ZW+1:OUT_SHIFT]);
        if (r > lim)
            r = lim;
        else if (r < -lim)
            r = -lim;
        return ROLL_W'(r);
    endfunction

    assign en         = !out_valid_reg || euler.ready;
    assign quat.ready = en;

    // products
    always_comb
    begin
        prod_next.wx = quat.quat_w * quat.quat_x;
        prod_next.yz = quat.quat_y * quat.quat_z;
        prod_next.xx = quat.quat_x * quat.quat_x;
        prod_next.yy = quat.quat_y * quat.quat_y;
        prod_next.wz = quat.quat_w * quat.quat_z;
        prod_next.xy = quat.quat_x * quat.quat_y;
        prod_next.zz = quat.quat_z * quat.quat_z;
        prod_next.wy = quat.quat_w * quat.quat_y;
        prod_next.zx = quat.quat_z * quat.quat_x;
    end

    // doubled sums
    always_comb
    begin
        sum_next.sr = (SUM_W'(prod_reg.wx) + SUM_W'(prod_reg.yz)) <<< 1;
        sum_next.cr = ONE_Q28 - ((SUM_W'(prod_reg.xx) + SUM_W'(prod_reg.yy)) <<< 1);
        sum_next.sy = (SUM_W'(prod_reg.wz) + SUM_W'(prod_reg.xy)) <<< 1;
        sum_next.cy = ONE_Q28 - ((SUM_W'(prod_reg.yy) + SUM_W'(prod_reg.zz)) <<< 1);
        sum_next.sp = (SUM_W'(prod_reg.wy) - SUM_W'(prod_reg.zx)) <<< 1;
    end

    // clamp test and sqrt operand 2^56 - sp^2
    always_comb
    begin
        mag            = (sum_reg.sp < 0) ? SUM_W'(-sum_reg.sp) : SUM_W'(sum_reg.sp);
        mag_sq         = mag[MAG_W-1:0] * mag[MAG_W-1:0];
        sq0_next.sums  = sum_reg;
        sq0_next.clamp = mag >= SUM_W'(ONE_Q28);
        sq0_next.root  = '0;
        sq0_next.rem   = (SQ_W'(1) << (2 * MAG_W)) - SQ_W'(mag_sq);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            sum_valid_reg  <= 1'b0;
            sq0_valid_reg  <= 1'b0;
            prep_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else if (en)
        begin
            prod_valid_reg <= quat.valid;
            sum_valid_reg  <= prod_valid_reg;
            sq0_valid_reg  <= sum_valid_reg;
            prep_valid_reg <= sq_valid[ROOT_W];
            out_valid_reg  <= rot_valid[ARC_ITERATIONS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg  <= prod_next;
            sum_reg   <= sum_next;
            sq0_reg   <= sq0_next;
            prep_reg  <= prep_next;
            roll_reg  <= roll_next;
            pitch_reg <= pitch_next;
            yaw_reg   <= yaw_next;
            clamp_reg <= fin.clamp;
        end
    end

    assign sq_valid[0] = sq0_valid_reg;
    assign sq_data[0]  = sq0_reg;

    for (genvar j = 0; j < ROOT_W; j++)
    begin : g_sqrt
        qte_sqrt_cell #(
            .BIT (ROOT_W - 1 - j)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (sq_valid[j]),
            .in_data   (sq_data[j]),
            .out_valid (sq_valid[j+1]),
            .out_data  (sq_data[j+1])
        );
    end

    // quadrant fold and start angles
    always_comb
    begin
        prep_next.roll  = prep_vec(sq_data[ROOT_W].sums.sr, sq_data[ROOT_W].sums.cr);
        prep_next.yaw   = prep_vec(sq_data[ROOT_W].sums.sy, sq_data[ROOT_W].sums.cy);
        prep_next.pitch = prep_vec(sq_data[ROOT_W].sums.sp,
                                   SUM_W'(sq_data[ROOT_W].root));
        prep_next.clamp = sq_data[ROOT_W].clamp;
        prep_next.neg   = sq_data[ROOT_W].sums.sp < 0;
    end

    assign rot_valid[0] = prep_valid_reg;
    assign rot_data[0]  = prep_reg;

    for (genvar s = 0; s < ARC_ITERATIONS; s++)
    begin : g_cordic
        qte_cordic_cell #(
            .STEP (s)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (rot_valid[s]),
            .in_data   (rot_data[s]),
            .out_valid (rot_valid[s+1]),
            .out_data  (rot_data[s+1])
        );
    end

    assign fin = rot_data[ARC_ITERATIONS];

    always_comb
    begin
        if (fin.clamp)
            pitch_ang = fin.neg ? -HALF_PI_Q30 : HALF_PI_Q30;
        else if (fin.pitch.zero)
            pitch_ang = '0;
        else
            pitch_ang = fin.pitch.z;
        roll_next  = to_out(fin.roll.zero ? '0 : fin.roll.z, FULL_LIMIT);
        yaw_next   = to_out(fin.yaw.zero ? '0 : fin.yaw.z, FULL_LIMIT);
        pitch_next = PITCH_W'(to_out(pitch_ang, HALF_LIMIT));
    end

    assign euler.valid         = out_valid_reg;
    assign euler.roll_doubled  = roll_reg;
    assign euler.pitch_doubled = pitch_reg;
    assign euler.yaw_doubled   = yaw_reg;
    assign euler.pitch_clamped = clamp_reg;

endmodule

@@ rtl/qte_sqrt_cell.sv @@
// One bit of the pipelined integer square root.
// Depends on qte_pkg.
`timescale 1ns / 1ps

module qte_sqrt_cell #(
    parameter int BIT = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  qte_pkg::qte_sq_t  in_data,
    output logic              out_valid,
    output qte_pkg::qte_sq_t  out_data
);
    import qte_pkg::*;

    localparam logic [SQ_W-1:0] BIT_SQ = SQ_W'(1) << (2 * BIT);

    logic             valid_reg;
    qte_sq_t          data_reg;
    qte_sq_t          data_next;
    logic [SQ_W-1:0]  trial;

    // (q + 2^k)^2 - q^2 = q*2^(k+1) + 2^(2k)
    always_comb
    begin
        data_next = in_data;
        trial     = (SQ_W'(in_data.root) << (BIT + 1)) + BIT_SQ;
        if (in_data.rem >= trial)
        begin
            data_next.rem  = in_data.rem - trial;
            data_next.root = in_data.root | (ROOT_W'(1) << BIT);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

@@ rtl/qte_cordic_cell.sv @@
// One CORDIC micro-rotation for the roll, pitch and yaw vectors.
// Depends on qte_pkg.
`timescale 1ns / 1ps

module qte_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  qte_pkg::qte_rot_t  in_data,
    output logic               out_valid,
    output qte_pkg::qte_rot_t  out_data
);
    import qte_pkg::*;

    logic      valid_reg;
    qte_rot_t  data_reg;
    qte_rot_t  data_next;

    always_comb
    begin
        data_next       = in_data;
        data_next.roll  = cordic_step(in_data.roll, STEP);
        data_next.pitch = cordic_step(in_data.pitch, STEP);
        data_next.yaw   = cordic_step(in_data.yaw, STEP);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

@@ test/quaternion_to_euler_angles_test.sv @@
// Self-checking testbench for quaternion_to_euler_angles: directed table, then
// random quaternions, each checked against a fixed-point angle predictor.
// Depends on qte_pkg, qte_if and the converter RTL.
`timescale 1ns / 1ps

module quaternion_to_euler_angles_test;

    import qte_pkg::*;

    localparam int  N_ITER      = ARC_ITER_DEF;
    localparam int  N_RANDOM    = 830;
    localparam int  CYCLE_LIMIT = 200000;
    localparam int  DRAIN       = 80;   // extra wait after the last expected transfer
    localparam int  UNKNOWN     = -99999;

    typedef struct {
        logic signed [ROLL_W-1:0]  roll;
        logic signed [PITCH_W-1:0] pitch;
        logic signed [ROLL_W-1:0]  yaw;
        logic                      clamp;
    } euler_t;

    // pitch and clamp typed in where obvious, UNKNOWN leaves it to the predictor
    typedef struct {
        int w, x, y, z;
        int pitch;
        int clamp;
    } quat_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    qte_quat_if  quat ();
    qte_euler_if euler ();

    quaternion_to_euler_angles uut (
        .clk   (clk),
        .rst_n (rst_n),
        .quat  (quat.sink),
        .euler (euler.source)
    );

    always #10 clk = ~clk;

    euler_t   angles_due[$];
    int       mismatches = 0;
    int       sent = 0;
    int       received = 0;
    int       clamped_seen = 0;
    int       cycles = 0;
    bit       steady = 1'b0;   // no idling on either side

    longint atan_q30[24] = '{
        843314856, 497837829, 263043836, 133525158, 67021686,
        33543515, 16775850, 8388437, 4194282, 2097149, 1048575,
        524287, 262143, 131071, 65535, 32767, 16383, 8191,
        4095, 2047, 1023, 511, 255, 127
    };

    function automatic longint vector_angle(longint y, longint x);
        longint z;
        longint dx;
        longint dy;
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        if (x < 0)
        begin
            z = (y >= 0) ? 64'sd3373259426 : -64'sd3373259426;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < N_ITER; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0)
            begin
                x += dx;
                y -= dy;
                z += atan_q30[i];
            end
            else
            begin
                x -= dx;
                y += dy;
                z -= atan_q30[i];
            end
        end
        return z;
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint doubled_q312(longint ang, longint lim);
        longint r;
        r = (2 * ang + 131072) >>> OUT_SHIFT;
        if (r > lim)
            r = lim;
        if (r < -lim)
            r = -lim;
        return r;
    endfunction

    function automatic euler_t predict_angles(int qw, int qx, int qy, int qz);
        euler_t         e;
        longint         w, x, y, z, sr, cr, sy, cy, sp, mag, pitch;
        longint unsigned rem;
        w = qw; x = qx; y = qy; z = qz;
        sr = 2 * (w * x + y * z);
        cr = 64'sd268435456 - 2 * (x * x + y * y);
        sy = 2 * (w * z + x * y);
        cy = 64'sd268435456 - 2 * (y * y + z * z);
        sp = 2 * (w * y - z * x);
        mag = sp < 0 ? -sp : sp;
        e.clamp = 1'b0;
        if (mag >= 64'sd268435456)
        begin
            pitch = sp < 0 ? -64'sd1686629713 : 64'sd1686629713;
            e.clamp = 1'b1;
        end
        else
        begin
            rem = (64'd1 << 56) - longint'(mag) * longint'(mag);
            pitch = vector_angle(sp, longint'(floor_sqrt(rem)));
        end
        e.roll  = ROLL_W'(doubled_q312(vector_angle(sr, cr), 25736));
        e.pitch = PITCH_W'(doubled_q312(pitch, 12868));
        e.yaw   = ROLL_W'(doubled_q312(vector_angle(sy, cy), 25736));
        return e;
    endfunction

    quat_row_t directed[] = '{
        '{16384, 0, 0, 0, UNKNOWN, 0},
        '{0, 0, 0, 0, UNKNOWN, 0},
        '{11585, 0, 11586, 0, 12868, 1},       // straight up, clamps
        '{11585, 0, -11586, 0, -12868, 1},
        '{16384, 0, 16384, 0, 12868, 1},
        '{16384, 0, -16384, 0, -12868, 1},
        '{0, 16384, 0, 16384, -12868, 1},      // clamp through the zx term
        '{-16384, -16384, -16384, -16384, UNKNOWN, UNKNOWN},
        '{16384, 16384, 16384, 16384, UNKNOWN, UNKNOWN},
        '{-16384, 16384, -16384, 16384, UNKNOWN, UNKNOWN},
        '{0, 16384, 0, 0, UNKNOWN, 0},         // roll near +-pi
        '{0, 0, 0, 16384, UNKNOWN, 0},         // yaw near +-pi
        '{0, 0, 16384, 0, UNKNOWN, 0},
        '{11585, 11585, 0, 0, UNKNOWN, 0},
        '{11585, 0, 0, 11585, UNKNOWN, 0},
        '{11585, 0, 0, -11585, UNKNOWN, 0},
        '{11585, -11585, 0, 0, UNKNOWN, 0},
        '{0, 0, 11585, 11585, UNKNOWN, UNKNOWN},
        '{-1, -1, -1, -1, UNKNOWN, 0},
        '{1, 1, 1, 1, UNKNOWN, 0},
        '{-32768 + 16384, 8192, -8192, 8192, UNKNOWN, UNKNOWN},
        '{16384, 16384, 0, 0, UNKNOWN, 0},     // non-unit
        '{5461, 10922, -13653, 2730, UNKNOWN, UNKNOWN}
    };

    task automatic send_quat(int qw, int qx, int qy, int qz, int typed_pitch,
                             int typed_clamp);
        euler_t e;
        e = predict_angles(qw, qx, qy, qz);
        if (typed_pitch != UNKNOWN)
            e.pitch = PITCH_W'(typed_pitch);
        if (typed_clamp != UNKNOWN)
            e.clamp = typed_clamp[0];
        while (!steady && $urandom_range(99) < 35)
        begin
            quat.valid = 1'b0;
            @(negedge clk);
        end
        quat.valid  = 1'b1;
        quat.quat_w = IN_W'(qw);
        quat.quat_x = IN_W'(qx);
        quat.quat_y = IN_W'(qy);
        quat.quat_z = IN_W'(qz);
        do
            @(posedge clk);
        while (!quat.ready);
        angles_due.push_back(e);
        sent++;
        @(negedge clk);
    endtask

    function automatic int signed_field();
        return $urandom_range(32768) - 16384;
    endfunction

    // sink side: random backpressure unless steady, changed at the falling edge
    always @(negedge clk)
        euler.ready <= steady ? 1'b1 : ($urandom_range(99) >= 35);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("quaternion_to_euler_angles_test failed");
            $finish;
        end
        if (rst_n && euler.valid && euler.ready)
        begin
            received++;
            if (euler.pitch_clamped)
                clamped_seen++;
            if (angles_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transfer: roll %0d pitch %0d yaw %0d",
                             euler.roll_doubled, euler.pitch_doubled,
                             euler.yaw_doubled);
            end
            else
            begin
                euler_t e;
                e = angles_due.pop_front();
                if (e.roll !== euler.roll_doubled || e.pitch !== euler.pitch_doubled
                    || e.yaw !== euler.yaw_doubled || e.clamp !== euler.pitch_clamped)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch #%0d: exp r %0d p %0d y %0d c %0b,",
                                  " got r %0d p %0d y %0d c %0b"},
                                 received, e.roll, e.pitch, e.yaw, e.clamp,
                                 euler.roll_doubled, euler.pitch_doubled,
                                 euler.yaw_doubled, euler.pitch_clamped);
                end
            end
        end
    end

    initial
    begin
        real a, b, c, d, n;
        int  kind;
        quat.valid  = 1'b0;
        quat.quat_w = '0;
        quat.quat_x = '0;
        quat.quat_y = '0;
        quat.quat_z = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed[i])
            send_quat(directed[i].w, directed[i].x, directed[i].y, directed[i].z,
                      directed[i].pitch, directed[i].clamp);

        for (int i = 0; i < N_RANDOM; i++)
        begin
            steady = (i >= 300 && i < 450);
            if (i == 500)
            begin
                quat.valid = 1'b0;
                while (angles_due.size() != 0)
                    @(negedge clk);
            end
            kind = $urandom_range(99);
            if (kind < 40)
                send_quat(signed_field(), signed_field(), signed_field(),
                          signed_field(), UNKNOWN, UNKNOWN);
            else if (kind < 80)
            begin
                // unit quaternion from random direction
                a = $urandom_range(20000) - 10000.0;
                b = $urandom_range(20000) - 10000.0;
                c = $urandom_range(20000) - 10000.0;
                d = $urandom_range(20000) - 10000.0;
                n = $sqrt(a * a + b * b + c * c + d * d) + 1.0e-9;
                send_quat($rtoi(16384.0 * a / n), $rtoi(16384.0 * b / n),
                          $rtoi(16384.0 * c / n), $rtoi(16384.0 * d / n),
                          UNKNOWN, UNKNOWN);
            end
            else
            begin
                // near gimbal lock, pitch argument close to one
                send_quat((kind[0] ? 11585 : -11585) + $urandom_range(8) - 4,
                          $urandom_range(200) - 100,
                          (kind[1] ? 11585 : -11585) + $urandom_range(8) - 4,
                          $urandom_range(200) - 100, UNKNOWN, UNKNOWN);
            end
        end
        quat.valid = 1'b0;
        steady = 1'b0;

        while (angles_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        $display("%0d quaternions sent, %0d angle sets checked, %0d with pitch clamped",
                 sent, received, clamped_seen);
        if (mismatches == 0)
            $display("quaternion_to_euler_angles_test passed");
        else
        begin
            $display("%0d mismatches", mismatches);
            $display("quaternion_to_euler_angles_test failed");
        end
        $finish;
    end

endmodule

@@ quaternion_to_euler_angles.f @@
rtl/qte_pkg.sv
rtl/qte_if.sv
rtl/qte_sqrt_cell.sv
rtl/qte_cordic_cell.sv
rtl/quaternion_to_euler_angles.sv
test/quaternion_to_euler_angles_test.sv
